// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the error log.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DERL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DERL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/derl_pkg.sv =====
// Types, codes and helpers of the deduplicating error ring log.
package derl_pkg;

  // Log geometry
  localparam int LOG_DEPTH = 128;
  localparam int ADDR_W    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W     = ADDR_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(LOG_DEPTH);

  localparam logic [7:0] REPEAT_MAX = 8'd255;

  // Item modes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] SEV_INFO = 2'd0;

  // Result status codes
  localparam logic [2:0] STAT_NEW      = 3'd0;
  localparam logic [2:0] STAT_MERGED   = 3'd1;
  localparam logic [2:0] STAT_FILTERED = 3'd2;
  localparam logic [2:0] STAT_READ_OK  = 3'd3;
  localparam logic [2:0] STAT_READ_OOR = 3'd4;
  localparam logic [2:0] STAT_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  severity;
    logic [15:0] err_code;
    logic [7:0]  err_source;
    logic [7:0]  controller_id;
    logic [31:0] payload_word;
    logic [31:0] timestamp_ms;
    logic [6:0]  read_position;
  } derl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entries;
    logic [31:0] out_timestamp;
    logic [31:0] out_payload;
    logic [15:0] out_code;
    logic [7:0]  out_source;
    logic [1:0]  out_severity;
    logic [7:0]  out_controller;
    logic [7:0]  out_repeats;
  } derl_out_t;

  // One stored record: key, time, data word, severity and repeat count
  typedef struct packed {
    logic [15:0] err_code;
    logic [7:0]  err_source;
    logic [7:0]  controller_id;
    logic [31:0] timestamp;
    logic [31:0] payload;
    logic [1:0]  severity;
    logic [7:0]  repeats;
  } derl_rec_t;

  // Slot of a record given the oldest slot and its age, wrapping at the depth
  function automatic logic [ADDR_W-1:0] age_slot(logic [ADDR_W-1:0] base,
                                                 logic [ADDR_W-1:0] age);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, age};
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/derl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module derl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/dedup_error_ring_log_core.sv =====
// Top level of the deduplicating error ring log.
//
// Usage: drive in_item and raise start; the beat is taken at a clock edge where
// start is high and busy is low. Every beat gives exactly one result beat on
// out_item, marked by out_strobe for a single cycle; the receiver cannot stall.
// Modes: append (info events are filtered), read the record of a given age
// (0 is the oldest), clear. Every result reports the record count after it.
// How a result is formed after the accepting edge:
//   filtered event, clear, out-of-range read, empty-log append: result register
//   in-range read: RAM read of the record, then the result register
//   append: a scan from the oldest record, ending at the first hit or the newest.
// All records live in one RAM with one read and one write port; an append
// scans the held records one read per cycle, oldest first, and stops at the
// first hit. busy stays high until the result is shown, and the next
// beat can be taken in the cycle that shows it.
// Reset (synchronous, rst_n low) empties the log: write pointer and count go to
// zero; the RAM contents are left as they are and are never read unwritten.
module dedup_error_ring_log_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  derl_pkg::derl_in_t in_item,
  output logic               out_strobe,
  output derl_pkg::derl_out_t out_item
);
  import derl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]        state_r, state_nxt;
  derl_in_t          in_r, in_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  age_r, age_nxt;
  logic [ADDR_W-1:0] rd_slot_r;
  logic              out_strobe_r, out_strobe_nxt;
  derl_out_t         out_r, out_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  derl_rec_t         ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  derl_rec_t         rd_rec;

  derl_in_t          cur;
  logic [SUM_W-1:0]  wp_s, held_s, oldest_s;
  logic [ADDR_W-1:0] oldest;
  logic              key_hit;

  derl_ram #(
    .WIDTH ($bits(derl_rec_t)),
    .DEPTH (LOG_DEPTH)
  ) u_rec_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_rec)
  );

  // Oldest held slot
  always_comb begin
    wp_s     = {1'b0, wp_r};
    held_s   = SUM_W'(held_r);
    oldest_s = (wp_s >= held_s) ? (wp_s - held_s) : (wp_s + DEPTH_S - held_s);
    oldest   = oldest_s[ADDR_W-1:0];
  end

  // The item being worked on: the incoming beat while idle, else the latched one
  assign cur = (state_r == ST_IDLE) ? in_item : in_r;

  assign key_hit = (rd_rec.err_code == in_r.err_code) &&
                   (rd_rec.err_source == in_r.err_source) &&
                   (rd_rec.controller_id == in_r.controller_id);

  // Sequencer: accept, scan or read, then write back and report
  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    wp_nxt         = wp_r;
    held_nxt       = held_r;
    age_nxt        = age_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = '0;
    ram_raddr      = oldest;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt         = in_item;
          out_nxt        = '0;
          out_strobe_nxt = 1'b1;
          case (in_item.mode)
            MODE_APPEND: begin
              if (in_item.severity == SEV_INFO) begin
                out_nxt.status = STAT_FILTERED;
              end else if (held_r == '0) begin
                // empty log: store right away
                ram_we         = 1'b1;
                out_nxt.status = STAT_NEW;
              end else begin
                out_strobe_nxt = 1'b0;
                ram_raddr      = oldest;
                age_nxt        = CNT_W'(1);
                state_nxt      = ST_SCAN;
              end
            end
            MODE_READ: begin
              if (32'(in_item.read_position) < 32'(held_r)) begin
                out_strobe_nxt = 1'b0;
                ram_raddr      = age_slot(oldest, ADDR_W'(in_item.read_position));
                state_nxt      = ST_READ;
              end else begin
                out_nxt.status = STAT_READ_OOR;
              end
            end
            MODE_CLEAR: begin
              wp_nxt         = '0;
              held_nxt       = '0;
              out_nxt.status = STAT_CLEARED;
            end
            default: begin
              out_nxt.status = STAT_FILTERED;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // compare the record read last cycle; on no hit, issue the next one if any is left
        out_nxt = '0;
        if (key_hit) begin
          ram_we             = 1'b1;
          ram_waddr          = rd_slot_r;
          ram_wdata          = rd_rec;
          ram_wdata.timestamp = in_r.timestamp_ms;
          if (rd_rec.repeats != REPEAT_MAX) ram_wdata.repeats = rd_rec.repeats + 8'd1;
          out_nxt.status     = STAT_MERGED;
          out_strobe_nxt     = 1'b1;
          state_nxt          = ST_IDLE;
        end else if (age_r < held_r) begin
          ram_raddr = age_slot(oldest, age_r[ADDR_W-1:0]);
          age_nxt   = age_r + CNT_W'(1);
        end else begin
          ram_we         = 1'b1;
          out_nxt.status = STAT_NEW;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      ST_READ: begin
        out_nxt.status         = STAT_READ_OK;
        out_nxt.out_timestamp  = rd_rec.timestamp;
        out_nxt.out_payload    = rd_rec.payload;
        out_nxt.out_code       = rd_rec.err_code;
        out_nxt.out_source     = rd_rec.err_source;
        out_nxt.out_severity   = rd_rec.severity;
        out_nxt.out_controller = rd_rec.controller_id;
        out_nxt.out_repeats    = rd_rec.repeats;
        out_strobe_nxt         = 1'b1;
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // New record at the write pointer; overwrites the oldest when full
    if (ram_we && (out_nxt.status == STAT_NEW)) begin
      ram_waddr               = wp_r;
      ram_wdata.err_code      = cur.err_code;
      ram_wdata.err_source    = cur.err_source;
      ram_wdata.controller_id = cur.controller_id;
      ram_wdata.timestamp     = cur.timestamp_ms;
      ram_wdata.payload       = cur.payload_word;
      ram_wdata.severity      = cur.severity;
      ram_wdata.repeats       = 8'd1;
      wp_nxt   = (wp_r == ADDR_W'(LOG_DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
      held_nxt = (held_r < CNT_W'(LOG_DEPTH)) ? held_r + CNT_W'(1) : held_r;
    end

    if (out_strobe_nxt) out_nxt.entries = 8'(held_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      held_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      held_r       <= held_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    age_r     <= age_nxt;
    rd_slot_r <= ram_raddr;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ===== hw/rtl/derl_checker.sv =====
// Port-level checks of the error log core, bound to the top level.
`include "assert_macros.svh"

module derl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input derl_pkg::derl_in_t  in_item,
  input logic                out_strobe,
  input derl_pkg::derl_out_t out_item
);
  import derl_pkg::*;

  logic in_beat;
  assign in_beat = start && !busy;

  // an accepted beat either answers at once or holds busy
  `DERL_ASSERT_NXT(a_beat_answered, in_beat, busy || out_strobe, "accepted beat left no trace")

  // a result is only shown when the core is free again
  `DERL_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result shown while busy")

  // busy only drops together with a result
  `DERL_ASSERT_IMP(a_busy_fall, $fell(busy), out_strobe, "busy fell without a result")

  // a clear answers in the next cycle with an empty log
  `DERL_ASSERT_NXT(a_clear_empty, in_beat && in_item.mode == MODE_CLEAR,
                   out_strobe && out_item.status == STAT_CLEARED && out_item.entries == 8'd0,
                   "clear did not report an empty log")

  // repeat count and error code are zero unless a read succeeded
  `DERL_ASSERT_IMP(a_fields_zero, out_strobe && out_item.status != STAT_READ_OK,
                   out_item.out_repeats == 8'd0 && out_item.out_code == 16'd0,
                   "record fields set on a non-read result")

endmodule

bind dedup_error_ring_log_core derl_checker u_derl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ===== test/dedup_error_ring_log_core_tb.sv =====
// Self-checking testbench of the deduplicating error ring log core.
module dedup_error_ring_log_core_tb;
  import derl_pkg::*;

  // Mode and severity codes the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] SEV_WARN    = 2'd1;
  localparam logic [1:0] SEV_ERR     = 2'd2;
  localparam logic [1:0] SEV_CRIT    = 2'd3;
  localparam int         NUM_STATUS  = 6;

  // Shadow copy of the log; predicts one result per accepted beat and checks it
  class error_log_checker;
    derl_rec_t   recs [LOG_DEPTH];
    int unsigned wr_ptr;
    int unsigned held;
    derl_out_t   awaited_results [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned saturated_hits;
    int unsigned status_seen [NUM_STATUS];

    function new();
      wr_ptr = 0;
      held = 0;
      errors = 0;
      checked = 0;
      saturated_hits = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned slot_at_age(int unsigned age);
      return (wr_ptr + LOG_DEPTH - held + age) % LOG_DEPTH;
    endfunction

    function logic [31:0] key_at_age(int unsigned age);
      derl_rec_t rec;
      rec = recs[slot_at_age(age)];
      return {rec.err_code, rec.err_source, rec.controller_id};
    endfunction

    // Update the shadow log for one accepted beat and queue its result
    function void apply_item(derl_in_t beat);
      derl_out_t   res;
      int unsigned s;
      bit          hit;
      res = '0;
      res.status = STAT_FILTERED;
      hit = 1'b0;
      case (beat.mode)
        MODE_APPEND: begin
          if (beat.severity != SEV_INFO) begin
            // oldest-first search for the same code, source and controller
            for (int unsigned age = 0; age < held && !hit; age++) begin
              s = slot_at_age(age);
              if (recs[s].err_code == beat.err_code &&
                  recs[s].err_source == beat.err_source &&
                  recs[s].controller_id == beat.controller_id) begin
                if (recs[s].repeats != REPEAT_MAX) recs[s].repeats++;
                else saturated_hits++;
                recs[s].timestamp = beat.timestamp_ms;
                hit = 1'b1;
              end
            end
            if (hit) begin
              res.status = STAT_MERGED;
            end else begin
              s = wr_ptr;
              recs[s].err_code      = beat.err_code;
              recs[s].err_source    = beat.err_source;
              recs[s].controller_id = beat.controller_id;
              recs[s].timestamp     = beat.timestamp_ms;
              recs[s].payload       = beat.payload_word;
              recs[s].severity      = beat.severity;
              recs[s].repeats       = 8'd1;
              wr_ptr = (wr_ptr + 1) % LOG_DEPTH;
              if (held < LOG_DEPTH) held++;
              res.status = STAT_NEW;
            end
          end
        end
        MODE_READ: begin
          if (beat.read_position < held) begin
            s = slot_at_age(32'(beat.read_position));
            res.out_timestamp  = recs[s].timestamp;
            res.out_payload    = recs[s].payload;
            res.out_code       = recs[s].err_code;
            res.out_source     = recs[s].err_source;
            res.out_severity   = recs[s].severity;
            res.out_controller = recs[s].controller_id;
            res.out_repeats    = recs[s].repeats;
            res.status = STAT_READ_OK;
          end else begin
            res.status = STAT_READ_OOR;
          end
        end
        MODE_CLEAR: begin
          wr_ptr = 0;
          held = 0;
          res.status = STAT_CLEARED;
        end
        default: ;
      endcase
      res.entries = 8'(held);
      status_seen[res.status]++;
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH beat %0d %s: got %h, expected %h", checked, what, got, want);
    endtask

    // Compare one result beat with the oldest prediction
    task check_result(derl_out_t got);
      derl_out_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none pending", {29'd0, got.status}, 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.entries !== want.entries)
          report_mismatch("entries", 32'(got.entries), 32'(want.entries));
        if (got.out_timestamp !== want.out_timestamp)
          report_mismatch("out_timestamp", got.out_timestamp, want.out_timestamp);
        if (got.out_payload !== want.out_payload)
          report_mismatch("out_payload", got.out_payload, want.out_payload);
        if (got.out_code !== want.out_code)
          report_mismatch("out_code", 32'(got.out_code), 32'(want.out_code));
        if (got.out_source !== want.out_source)
          report_mismatch("out_source", 32'(got.out_source), 32'(want.out_source));
        if (got.out_severity !== want.out_severity)
          report_mismatch("out_severity", 32'(got.out_severity), 32'(want.out_severity));
        if (got.out_controller !== want.out_controller)
          report_mismatch("out_controller", 32'(got.out_controller),
                          32'(want.out_controller));
        if (got.out_repeats !== want.out_repeats)
          report_mismatch("out_repeats", 32'(got.out_repeats), 32'(want.out_repeats));
        checked++;
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  derl_in_t  in_item;
  logic      out_strobe;
  derl_out_t out_item;

  error_log_checker sb = new();
  bit               gapless = 1'b0;
  logic [31:0]      key_pool [24];

  dedup_error_ring_log_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Beat with every field random; callers overwrite what matters
  function automatic derl_in_t rand_beat();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(derl_in_t)-1:0];
  endfunction

  function automatic derl_in_t append_beat(logic [1:0] sev, logic [31:0] key);
    derl_in_t b;
    b = rand_beat();
    b.mode = MODE_APPEND;
    b.severity = sev;
    {b.err_code, b.err_source, b.controller_id} = key;
    return b;
  endfunction

  function automatic derl_in_t read_beat(logic [6:0] pos);
    derl_in_t b;
    b = rand_beat();
    b.mode = MODE_READ;
    b.read_position = pos;
    return b;
  endfunction

  function automatic derl_in_t mode_beat(logic [1:0] mode);
    derl_in_t b;
    b = rand_beat();
    b.mode = mode;
    return b;
  endfunction

  // Read position: mostly inside the held records, sometimes anywhere
  function automatic logic [6:0] pick_position();
    if (sb.held != 0 && $urandom_range(0, 3) != 0)
      return 7'($urandom_range(0, sb.held - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [1:0] pick_severity();
    return 2'($urandom_range(1, 3));
  endfunction

  // Drive one beat after a random gap and wait until it is taken
  task automatic send_item(input derl_in_t beat);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) gapless = !gapless;
    gap = gapless ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.apply_item(beat);
  endtask

  // Result monitor; results cannot be held off
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_strobe)) sb.report_mismatch("out_strobe unknown", 32'd0, 32'd0);
      else if (out_strobe) sb.check_result(out_item);
    end
  end

  // Main sequence
  initial begin
    derl_in_t    b;
    int unsigned r;
    int unsigned waited;
    logic [31:0] key;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    // pool keys 1..3 each differ from key 0 in one bit of code, source or controller
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[1] = key_pool[0] ^ 32'h0001_0000;
    key_pool[2] = key_pool[0] ^ 32'h0000_0100;
    key_pool[3] = key_pool[0] ^ 32'h0000_0001;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty log, filtering, unused mode, field extremes, merge
    send_item(read_beat(7'd0));
    send_item(read_beat(7'd127));
    send_item(append_beat(SEV_INFO, $urandom));
    send_item(mode_beat(MODE_UNUSED));
    send_item(mode_beat(MODE_CLEAR));
    b = append_beat(SEV_WARN, 32'h0);
    b.payload_word = 32'h0;
    b.timestamp_ms = 32'h0;
    send_item(b);
    b = append_beat(SEV_CRIT, 32'hFFFF_FFFF);
    b.payload_word = 32'hFFFF_FFFF;
    b.timestamp_ms = 32'hFFFF_FFFF;
    send_item(b);
    // duplicate keeps severity and payload of the first record
    b = append_beat(SEV_ERR, 32'h0);
    b.payload_word = 32'hFFFF_FFFF;
    b.timestamp_ms = 32'h0000_1234;
    send_item(b);
    send_item(append_beat(SEV_INFO, 32'h0));
    send_item(append_beat(SEV_ERR, 32'h0001_0000));
    send_item(append_beat(SEV_ERR, 32'h0000_0100));
    send_item(append_beat(SEV_ERR, 32'h0000_0001));
    for (int p = 0; p < 6; p++) send_item(read_beat(7'(p)));
    send_item(mode_beat(MODE_CLEAR));
    send_item(read_beat(7'd0));
    send_item(append_beat(SEV_CRIT, $urandom));
    send_item(read_beat(7'd0));

    // Fill past the depth so the oldest records get overwritten
    for (int n = 0; n < 180; n++) begin
      r = $urandom_range(0, 9);
      if (r < 8) send_item(append_beat(pick_severity(), $urandom));
      else if (r == 8) send_item(read_beat(pick_position()));
      else send_item(append_beat(pick_severity(),
                                 sb.key_at_age($urandom_range(0, sb.held - 1))));
    end

    // Full log: edge ages, near-miss keys, then drive one key past saturation
    send_item(read_beat(7'd0));
    send_item(read_beat(7'd127));
    for (int k = 1; k < 4; k++) send_item(append_beat(pick_severity(), key_pool[k]));
    for (int n = 0; n < 280; n++) begin
      if (n % 12 == 11) send_item(read_beat(pick_position()));
      else send_item(append_beat(pick_severity(), key_pool[0]));
    end
    send_item(read_beat(7'(sb.held - 1)));
    send_item(mode_beat(MODE_CLEAR));

    // Mixed traffic: pool keys, held keys, fresh keys, reads, noise
    for (int n = 0; n < 580; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 9);
        if (r < 4) key = key_pool[$urandom_range(0, 23)];
        else if (r < 7 && sb.held != 0) key = sb.key_at_age($urandom_range(0, sb.held - 1));
        else key = $urandom;
        send_item(append_beat(pick_severity(), key));
      end else if (r < 62) begin
        send_item(append_beat(SEV_INFO, key_pool[$urandom_range(0, 23)]));
      end else if (r < 92) begin
        send_item(read_beat(pick_position()));
      end else if (r < 97) begin
        send_item(mode_beat(MODE_UNUSED));
      end else begin
        send_item(mode_beat(MODE_CLEAR));
      end
    end
    start <= 1'b0;

    // Drain
    waited = 0;
    while (sb.awaited_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.awaited_results.size() != 0)
      sb.report_mismatch("results never seen", sb.awaited_results.size(), 32'd0);

    $display("Checked %0d result beats: %0d new, %0d merged (%0d at repeat limit), %0d filtered",
             sb.checked, sb.status_seen[STAT_NEW], sb.status_seen[STAT_MERGED],
             sb.saturated_hits, sb.status_seen[STAT_FILTERED]);
    $display("  %0d reads in range, %0d out of range, %0d clears, %0d mismatches",
             sb.status_seen[STAT_READ_OK], sb.status_seen[STAT_READ_OOR],
             sb.status_seen[STAT_CLEARED], sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/derl_pkg.sv
hw/rtl/derl_ram.sv
hw/rtl/dedup_error_ring_log_core.sv
hw/rtl/derl_checker.sv
test/dedup_error_ring_log_core_tb.sv
